### sv/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define HSVC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define HSVC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/hsvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

    localparam int HUE_W   = 13;
    localparam int CHAN_W  = 8;
    localparam int SECT_W  = 3;
    localparam int RAW_W   = 4;
    localparam int K_W     = 10;
    localparam int PROD_W  = 16;
    localparam int NUM_W   = 26;

    localparam int HUE_PER_SECTOR = 960;
    localparam int SECTOR_COUNT   = 6;
    localparam int FULL_SCALE     = 255;
    localparam int MAX_SECTOR_RAW = (2 ** HUE_W - 1) / HUE_PER_SECTOR;
    localparam int DENOM          = FULL_SCALE * HUE_PER_SECTOR;

    // floor(x / 255) ~ (x * 257) >> 16, low by at most one
    localparam int RECIP_255      = 257;
    localparam int RECIP_255_SH   = 16;
    localparam int X2_PROD_W      = 24;

    // floor(n / 244800) ~ (n * 17544) >> 32, low by at most one
    localparam int RECIP_DEN_SH   = 32;
    localparam int RECIP_DEN      = int'((64'd1 << RECIP_DEN_SH) / DENOM);
    localparam int N_PROD_W       = 41;

    localparam int PIPE_STAGES    = 6;
    localparam int FRONT_STAGES   = 3;
    localparam int BACK_STAGES    = PIPE_STAGES - FRONT_STAGES;

    typedef logic [SECT_W-1:0] sector_t;
    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        sector_t            sector;
        chan_t              v;
        logic [NUM_W-1:0]   n;
        chan_t              lvl_min;
    } front_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef enum logic [SECT_W-1:0] {
        SECT_RED_YEL   = 3'd0,
        SECT_YEL_GRN   = 3'd1,
        SECT_GRN_CYN   = 3'd2,
        SECT_CYN_BLU   = 3'd3,
        SECT_BLU_MAG   = 3'd4,
        SECT_MAG_RED   = 3'd5
    } sector_e;

    // c = chroma + min, x = ramp + min, z = min
    function automatic rgb_t map_rgb(sector_t sector, chan_t c, chan_t x, chan_t z);
        rgb_t o;
        case (sector)
            SECT_RED_YEL: o = '{red: c, green: x, blue: z};
            SECT_YEL_GRN: o = '{red: x, green: c, blue: z};
            SECT_GRN_CYN: o = '{red: z, green: c, blue: x};
            SECT_CYN_BLU: o = '{red: z, green: x, blue: c};
            SECT_BLU_MAG: o = '{red: x, green: z, blue: c};
            SECT_MAG_RED: o = '{red: c, green: z, blue: x};
            default:      o = '{red: c, green: z, blue: x};
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

### sv/hsvc_ctl.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_ctl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            up_valid,
    output logic                                 up_stall,
    output logic [hsvc_pkg::PIPE_STAGES-1:0]     en,
    output logic                                 down_valid,
    input  wire logic                            down_stall
);
    import hsvc_pkg::*;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || !down_stall;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = up_valid;
        end
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign up_stall   = !en[0];
    assign down_valid = valid_reg[PIPE_STAGES-1];

endmodule

`default_nettype wire

### sv/hsvc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_front (
    input  wire logic                              clk,
    input  wire logic [hsvc_pkg::FRONT_STAGES-1:0] en,
    input  wire logic [hsvc_pkg::HUE_W-1:0]        hue,
    input  wire hsvc_pkg::chan_t                   saturation,
    input  wire hsvc_pkg::chan_t                   brightness,
    output hsvc_pkg::front_t                       front
);
    import hsvc_pkg::*;

    // stage 1: sector decode, s*v and v*(255-s)
    logic [RAW_W-1:0]  sraw;
    logic [K_W-1:0]    rem;
    sector_t           sector_next;
    logic [K_W-1:0]    k_next;
    logic [PROD_W-1:0] sv_next;
    logic [PROD_W-1:0] x2_next;

    sector_t           sector1_reg;
    logic [K_W-1:0]    k1_reg;
    logic [PROD_W-1:0] sv1_reg;
    logic [PROD_W-1:0] x21_reg;
    chan_t             v1_reg;

    always_comb
    begin
        sraw = '0;
        for (int i = 1; i <= MAX_SECTOR_RAW; i++)
        begin
            if (hue >= HUE_W'(i * HUE_PER_SECTOR))
            begin
                sraw = RAW_W'(i);
            end
        end
        rem = K_W'(hue - HUE_W'(sraw * HUE_PER_SECTOR));
        if (sraw >= RAW_W'(SECTOR_COUNT))
        begin
            sector_next = SECT_W'(sraw - RAW_W'(SECTOR_COUNT));
        end
        else
        begin
            sector_next = sraw[SECT_W-1:0];
        end
        k_next  = sraw[0] ? rem : K_W'(HUE_PER_SECTOR) - rem;
        sv_next = PROD_W'(saturation) * PROD_W'(brightness);
        x2_next = PROD_W'(brightness) * PROD_W'(CHAN_W'(FULL_SCALE) - saturation);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sector1_reg <= sector_next;
            k1_reg      <= k_next;
            sv1_reg     <= sv_next;
            x21_reg     <= x2_next;
            v1_reg      <= brightness;
        end
    end

    // stage 2: s*v*k, 244800*v, coarse v*(255-s)/255
    logic [NUM_W-1:0]     p_next;
    logic [NUM_W-1:0]     a_next;
    logic [X2_PROD_W-1:0] x2_prod;

    logic [NUM_W-1:0]  p2_reg;
    logic [NUM_W-1:0]  a2_reg;
    chan_t             q2_reg;
    logic [PROD_W-1:0] x22_reg;
    sector_t           sector2_reg;
    chan_t             v2_reg;

    assign p_next  = NUM_W'(sv1_reg) * NUM_W'(k1_reg);
    assign a_next  = NUM_W'(v1_reg) * NUM_W'(DENOM);
    assign x2_prod = X2_PROD_W'(x21_reg) * X2_PROD_W'(RECIP_255);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p2_reg      <= p_next;
            a2_reg      <= a_next;
            q2_reg      <= x2_prod[RECIP_255_SH +: CHAN_W];
            x22_reg     <= x21_reg;
            sector2_reg <= sector1_reg;
            v2_reg      <= v1_reg;
        end
    end

    // stage 3: numerator of the ramp level, fix up the min level
    logic [PROD_W-1:0] r2;
    front_t            front_next;
    front_t            front_reg;

    always_comb
    begin
        r2                 = x22_reg - PROD_W'(q2_reg) * PROD_W'(FULL_SCALE);
        front_next.sector  = sector2_reg;
        front_next.v       = v2_reg;
        front_next.n       = a2_reg - p2_reg;
        front_next.lvl_min = (r2 >= PROD_W'(FULL_SCALE)) ? q2_reg + 1'b1 : q2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

### sv/hsvc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_back (
    input  wire logic                             clk,
    input  wire logic [hsvc_pkg::BACK_STAGES-1:0] en,
    input  wire hsvc_pkg::front_t                 front,
    output hsvc_pkg::chan_t                       red,
    output hsvc_pkg::chan_t                       green,
    output hsvc_pkg::chan_t                       blue
);
    import hsvc_pkg::*;

    // stage 4: coarse n / 244800 by reciprocal
    logic [N_PROD_W-1:0] n_prod;
    chan_t               q4_reg;
    front_t              f4_reg;

    assign n_prod = N_PROD_W'(front.n) * N_PROD_W'(RECIP_DEN);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q4_reg <= n_prod[RECIP_DEN_SH +: CHAN_W];
            f4_reg <= front;
        end
    end

    // stage 5: one-step correction of the quotient
    logic [NUM_W-1:0] r1;
    chan_t            lvl_x_next;
    chan_t            lvl_x5_reg;
    chan_t            lvl_min5_reg;
    chan_t            v5_reg;
    sector_t          sector5_reg;

    always_comb
    begin
        r1         = f4_reg.n - NUM_W'(q4_reg) * NUM_W'(DENOM);
        lvl_x_next = (r1 >= NUM_W'(DENOM)) ? q4_reg + 1'b1 : q4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            lvl_x5_reg   <= lvl_x_next;
            lvl_min5_reg <= f4_reg.lvl_min;
            v5_reg       <= f4_reg.v;
            sector5_reg  <= f4_reg.sector;
        end
    end

    // stage 6: sector routing into the output register
    rgb_t rgb_next;
    rgb_t rgb_reg;

    assign rgb_next = map_rgb(sector5_reg, v5_reg, lvl_x5_reg, lvl_min5_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign red   = rgb_reg.red;
    assign green = rgb_reg.green;
    assign blue  = rgb_reg.blue;

endmodule

`default_nettype wire

### sv/hsv_to_rgb_pixel_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// HSV to 8-bit RGB, one pixel per clock while the output is not stalled. Hue
// is in 1/16 degree (values past 5759 wrap the sector modulo six); saturation
// and brightness are 8-bit fractions. Each channel is floor(255 * level)
// computed exactly. A beat passes six register stages on its way to the
// outputs; the stages are sector decode with the s*v products, the s*v*k
// product, the numerator subtract, the reciprocal multiply for the divide by
// 244800, its correction, and sector routing.
// Every stage loads on its own enable, so a stall on the output only holds
// the full stages and empty ones keep taking beats. Reset clears the valid
// bits only.
module hsv_to_rgb_pixel_converter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       hsv_valid,
    output logic                            hsv_stall,
    input  wire logic [hsvc_pkg::HUE_W-1:0] hue,
    input  wire hsvc_pkg::chan_t            saturation,
    input  wire hsvc_pkg::chan_t            brightness,
    output logic                            rgb_valid,
    input  wire logic                       rgb_stall,
    output hsvc_pkg::chan_t                 red,
    output hsvc_pkg::chan_t                 green,
    output hsvc_pkg::chan_t                 blue
);
    import hsvc_pkg::*;

    logic [PIPE_STAGES-1:0] en;
    front_t                 front;

    hsvc_ctl u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (hsv_valid),
        .up_stall   (hsv_stall),
        .en         (en),
        .down_valid (rgb_valid),
        .down_stall (rgb_stall)
    );

    hsvc_front u_front (
        .clk        (clk),
        .en         (en[FRONT_STAGES-1:0]),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .front      (front)
    );

    hsvc_back u_back (
        .clk   (clk),
        .en    (en[PIPE_STAGES-1:FRONT_STAGES]),
        .front (front),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

endmodule

`default_nettype wire

### sv/hsvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsvc_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       hsv_valid,
    input wire logic                       hsv_stall,
    input wire logic [hsvc_pkg::HUE_W-1:0] hue,
    input wire hsvc_pkg::chan_t            saturation,
    input wire hsvc_pkg::chan_t            brightness,
    input wire logic                       rgb_valid,
    input wire logic                       rgb_stall,
    input wire hsvc_pkg::chan_t            red,
    input wire hsvc_pkg::chan_t            green,
    input wire hsvc_pkg::chan_t            blue
);
    import hsvc_pkg::*;

    logic hsv_beat;
    logic [HUE_W-1:0] hue_seen;

    assign hsv_beat = hsv_valid && !hsv_stall;
    assign hue_seen = hue;

    `HSVC_ASSERT_NEXT(a_out_hold, rgb_valid && rgb_stall, rgb_valid && $stable(red) && $stable(green) && $stable(blue), "output beat changed under stall")

    `HSVC_ASSERT_SAME(a_empty_out_takes, !rgb_valid, !hsv_stall, "input stalled with empty output")

    `HSVC_ASSERT_NEXT(a_latency, hsv_beat ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall, rgb_valid, "beat missing after six free cycles")

    `HSVC_ASSERT_NEXT(a_gray, hsv_beat && saturation == '0 ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall, red == green && green == blue, "zero saturation not gray")

    `HSVC_ASSERT_NEXT(a_black, hsv_beat && brightness == '0 && hue_seen == hue ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall, red == '0 && green == '0 && blue == '0, "zero brightness not black")

endmodule

bind hsv_to_rgb_pixel_converter hsvc_checker u_hsvc_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import hsvc_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [HUE_W-1:0] hue;
        chan_t            sat;
        chan_t            val;
        rgb_t             rgb;
    } pixel_expect_t;

    class rgb_scoreboard;
        pixel_expect_t waiting[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        static function rgb_t convert_pixel(logic [HUE_W-1:0] h, chan_t s, chan_t v);
            int unsigned sector_raw;
            int unsigned rem;
            int unsigned k;
            int unsigned vv;
            int unsigned ss;
            chan_t       lvl_c;
            chan_t       lvl_x;
            chan_t       lvl_z;
            sector_e     sector;
            rgb_t        o;
            vv = v;
            ss = s;
            sector_raw = h / HUE_PER_SECTOR;
            rem = h % HUE_PER_SECTOR;
            sector = sector_e'(sector_raw % SECTOR_COUNT);
            k = sector_raw[0] ? rem : HUE_PER_SECTOR - rem;
            lvl_c = chan_t'(vv);
            lvl_x = chan_t'((DENOM * vv - ss * vv * k) / DENOM);
            lvl_z = chan_t'((vv * (FULL_SCALE - ss)) / FULL_SCALE);
            case (sector)
                SECT_RED_YEL: o = '{red: lvl_c, green: lvl_x, blue: lvl_z};
                SECT_YEL_GRN: o = '{red: lvl_x, green: lvl_c, blue: lvl_z};
                SECT_GRN_CYN: o = '{red: lvl_z, green: lvl_c, blue: lvl_x};
                SECT_CYN_BLU: o = '{red: lvl_z, green: lvl_x, blue: lvl_c};
                SECT_BLU_MAG: o = '{red: lvl_x, green: lvl_z, blue: lvl_c};
                default:      o = '{red: lvl_c, green: lvl_z, blue: lvl_x};
            endcase
            return o;
        endfunction

        function void note_pixel(logic [HUE_W-1:0] h, chan_t s, chan_t v);
            pixel_expect_t e;
            e.hue = h;
            e.sat = s;
            e.val = v;
            e.rgb = convert_pixel(h, s, v);
            waiting.push_back(e);
        endfunction

        function void check_pixel(chan_t r, chan_t g, chan_t b);
            pixel_expect_t e;
            if (waiting.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected rgb beat: %0d %0d %0d", r, g, b);
                return;
            end
            e = waiting.pop_front();
            if (r !== e.rgb.red || g !== e.rgb.green || b !== e.rgb.blue)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch hsv=(%0d,%0d,%0d): expected %0d %0d %0d, got %0d %0d %0d",
                             e.hue, e.sat, e.val, e.rgb.red, e.rgb.green, e.rgb.blue,
                             r, g, b);
            end
        endfunction

        function int pending();
            return waiting.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             hsv_valid;
    logic             hsv_stall;
    logic [HUE_W-1:0] hue;
    chan_t            saturation;
    chan_t            brightness;
    logic             rgb_valid;
    logic             rgb_stall;
    chan_t            red;
    chan_t            green;
    chan_t            blue;

    bit               rx_bursty;
    bit               hold_on;
    int               hold_reqs;
    rgb_scoreboard    board;

    hsv_to_rgb_pixel_converter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 90)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic chan_t pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 3))
                0: return 8'd0;
                1: return 8'd255;
                2: return 8'd1;
                default: return 8'd254;
            endcase
        end
        return chan_t'($urandom_range(0, 255));
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return HUE_W'($urandom_range(0, MAX_SECTOR_RAW - 1) * HUE_PER_SECTOR
                          + ($urandom_range(0, 1) ? HUE_PER_SECTOR - 1 : 0));
        else if (r < 85)
            return HUE_W'($urandom_range(0, 5759));
        return HUE_W'($urandom_range(5760, 8191));
    endfunction

    // receiver: checks accepted beats, drives random stall plus the long hold
    initial
    begin
        int stall_left;
        bit stall;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rgb_valid && !rgb_stall)
                board.check_pixel(red, green, blue);
            if (stall_left > 0)
            begin
                stall_left--;
                stall = 1'b1;
            end
            else if (rx_bursty && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                stall = 1'b1;
            end
            else
                stall = 1'b0;
            rgb_stall <= stall || hold_on;
        end
    end

    initial
    begin
        int served;
        served = 0;
        hold_on = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != served)
            begin
                served = hold_reqs;
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        end
    end

    task automatic send_pixel(input logic [HUE_W-1:0] h, input chan_t s, input chan_t v,
                              input bit bursty);
        int gap;
        gap = (bursty && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0)
        begin
            hsv_valid  <= 1'b0;
            hue        <= HUE_W'($urandom);
            saturation <= chan_t'($urandom);
            brightness <= chan_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        hsv_valid  <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (hsv_stall)
            @(posedge clk);
        board.note_pixel(h, s, v);
    endtask

    task automatic send_random(input int count, input bit bursty);
        repeat (count)
            send_pixel(pick_hue(), pick_level(), pick_level(), bursty);
    endtask

    task automatic drain();
        hsv_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board      = new();
        rst_n      = 1'b0;
        hsv_valid  = 1'b0;
        hue        = '0;
        saturation = '0;
        brightness = '0;
        rgb_stall  = 1'b0;
        rx_bursty  = 1'b0;
        hold_reqs  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector edges, out-of-range hue, zero saturation and zero brightness
        send_pixel(0, 255, 255, 0);
        send_pixel(480, 255, 255, 0);
        send_pixel(959, 255, 255, 0);
        send_pixel(960, 255, 255, 0);
        send_pixel(1440, 255, 255, 0);
        send_pixel(1919, 255, 255, 0);
        send_pixel(1920, 255, 255, 0);
        send_pixel(2880, 200, 255, 0);
        send_pixel(3840, 255, 200, 0);
        send_pixel(4800, 128, 255, 0);
        send_pixel(5280, 255, 128, 0);
        send_pixel(5759, 255, 255, 0);
        send_pixel(5760, 255, 255, 0);
        send_pixel(6720, 255, 255, 0);
        send_pixel(7680, 255, 255, 0);
        send_pixel(8191, 255, 255, 0);
        send_pixel(3000, 0, 200, 0);
        send_pixel(3000, 255, 0, 0);
        send_pixel(0, 0, 0, 0);
        send_pixel(1, 1, 1, 0);
        send_pixel(4321, 254, 254, 0);
        send_pixel(2000, 128, 128, 0);
        send_pixel(5000, 1, 255, 0);
        send_pixel(100, 255, 1, 0);
        drain();

        rx_bursty <= 1'b1;
        send_random(300, 1);
        drain();

        // long output hold while beats keep coming back to back
        hold_reqs <= hold_reqs + 1;
        send_random(40, 0);
        drain();

        rx_bursty <= 1'b0;
        send_random(200, 0);
        rx_bursty <= 1'b1;
        send_random(240, 1);
        drain();
        repeat (20) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
